### hw/rtl/form_field_value_extractor_top_assert.svh
// Assertion helpers for the RTL
`ifndef FORM_FIELD_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define FORM_FIELD_VALUE_EXTRACTOR_TOP_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define FFVE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("ffve: invariant violated");

// when ante holds, cons must hold in the next cycle
`define FFVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffve: next-cycle check failed");

`endif

### hw/rtl/ffve_pkg.sv
`timescale 1ns / 1ps
package ffve_pkg;

	localparam int MAX_KEY_CHARS = 8;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// register index, taken from paddr[3]
	localparam logic REG_KEY_TEXT   = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	typedef struct packed {
		logic       has;
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       value_end;
		logic       key_found;
	} ffve_res_t;

	function automatic logic [3:0] hex_digit(input logic [7:0] b);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (b >= 8'h30 && b <= 8'h39) begin
				d = b - 8'h30;
			end else if (b >= 8'h61 && b <= 8'h66) begin
				d = b - 8'h57;
			end else if (b >= 8'h41 && b <= 8'h46) begin
				d = b - 8'h37;
			end
			return d[3:0];
		end
	endfunction

	function automatic logic is_space(input logic [7:0] v);
		return (v == CH_SPACE) || (v == CH_TAB) || (v == CH_CR) || (v == CH_LF);
	endfunction

endpackage

### hw/rtl/ffve_scan.sv
`timescale 1ns / 1ps
`include "form_field_value_extractor_top_assert.svh"
module ffve_scan
	import ffve_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  in_byte,
	input  logic        end_of_text,
	input  logic [63:0] key_text,
	input  logic [3:0]  key_length,
	output ffve_res_t   res
);

	localparam logic [1:0] PH_NAME  = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_ONE  = 2'd2;

	logic [1:0] phase_q, phase_n;
	logic [3:0] cnt_q, cnt_n;
	logic [7:0] prev_q, prev_n;
	logic [1:0] esc_q, esc_n;
	logic [7:0] ev_q, ev_n;
	logic       endr_q, endr_n;

	logic       term;
	logic [3:0] klen;
	logic [7:0] key_ch;
	logic [7:0] ev_new;
	logic       fin;
	logic [7:0] fin_v;
	logic       emit;
	logic [7:0] ch;
	logic       vend;
	logic       found;
	logic       state_clear;

	assign term   = end_of_text || (in_byte == 8'h00);
	assign klen   = (key_length > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : key_length;
	assign key_ch = key_text[{cnt_q[2:0], 3'b000} +: 8];
	assign ev_new = {ev_q[3:0], hex_digit(in_byte)};

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		prev_n  = prev_q;
		esc_n   = esc_q;
		ev_n    = ev_q;
		endr_n  = endr_q;
		emit    = 1'b0;
		ch      = 8'h00;
		vend    = 1'b0;
		found   = 1'b0;
		fin     = 1'b0;
		fin_v   = 8'h00;

		if (in_byte != 8'h00) begin
			unique case (phase_q)
				PH_NAME: begin
					if (cnt_q < klen && in_byte == key_ch) begin
						cnt_n = cnt_q + 4'd1;
					end else if (cnt_q >= klen && in_byte == CH_EQ) begin
						phase_n = PH_VALUE;
						prev_n  = CH_SPACE;
					end else if (in_byte == CH_AMP) begin
						cnt_n = 4'd0;
					end else begin
						phase_n = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (in_byte == CH_AMP) begin
						phase_n = PH_NAME;
						cnt_n   = 4'd0;
					end
				end
				PH_VALUE: begin
					if (esc_q != ESC_NONE) begin
						if (esc_q == ESC_PCT) begin
							esc_n = ESC_ONE;
							ev_n  = ev_new;
						end else begin
							fin   = 1'b1;
							fin_v = ev_new;
						end
					end else if (in_byte == CH_AMP) begin
						phase_n = PH_DONE;
						endr_n  = 1'b1;
						vend    = 1'b1;
						found   = 1'b1;
					end else if (in_byte == CH_PLUS) begin
						emit   = (prev_q != CH_SPACE);
						ch     = CH_SPACE;
						prev_n = CH_SPACE;
					end else if (in_byte == CH_PCT) begin
						esc_n = ESC_PCT;
						ev_n  = 8'h00;
					end else begin
						prev_n = in_byte;
						emit   = 1'b1;
						ch     = in_byte;
					end
				end
				default: begin
				end
			endcase
		end

		// end of text or a NUL byte flushes a half-read escape
		if (term && !fin && phase_n == PH_VALUE && esc_n != ESC_NONE) begin
			fin   = 1'b1;
			fin_v = (esc_n == ESC_PCT) ? 8'h00 : {ev_n[3:0], 4'h0};
		end

		if (fin) begin
			esc_n = ESC_NONE;
			ev_n  = 8'h00;
			if (is_space(fin_v)) begin
				emit   = (prev_n != CH_SPACE);
				ch     = CH_SPACE;
				prev_n = CH_SPACE;
			end else begin
				prev_n = fin_v;
				emit   = (fin_v != 8'h00);
				ch     = fin_v;
			end
		end

		if (term) begin
			if (!endr_n) begin
				vend  = 1'b1;
				found = (phase_n == PH_VALUE);
			end
			phase_n = PH_NAME;
			cnt_n   = 4'd0;
			prev_n  = CH_SPACE;
			esc_n   = ESC_NONE;
			ev_n    = 8'h00;
			endr_n  = 1'b0;
		end
	end

	assign res.has        = emit || vend;
	assign res.value_byte = emit ? ch : 8'h00;
	assign res.byte_valid = emit;
	assign res.value_end  = vend;
	assign res.key_found  = vend && found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			cnt_q   <= 4'd0;
			prev_q  <= CH_SPACE;
			esc_q   <= ESC_NONE;
			ev_q    <= 8'h00;
			endr_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			prev_q  <= prev_n;
			esc_q   <= esc_n;
			ev_q    <= ev_n;
			endr_q  <= endr_n;
		end
	end

	assign state_clear = (phase_q == PH_NAME) && (cnt_q == 4'd0) && (esc_q == ESC_NONE) &&
		!endr_q && (prev_q == CH_SPACE);

	`FFVE_ASSERT_ALWAYS(a_esc_only_in_value, clk, arst_n, (esc_q == ESC_NONE) || (phase_q == PH_VALUE))
	`FFVE_ASSERT_ALWAYS(a_end_means_done, clk, arst_n, !endr_q || (phase_q == PH_DONE))
	`FFVE_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, (cnt_q <= 4'(MAX_KEY_CHARS)) && (esc_q != 2'd3))
	`FFVE_ASSERT_NEXT(a_rearm, clk, arst_n, step && term, state_clear)

endmodule

### hw/rtl/form_field_value_extractor_top.sv
`timescale 1ns / 1ps
// channel   dir  request                        sideband
// s_axis    in   tdata = in_byte                tlast = end_of_text
// m_axis    out  tdata = value_byte             tlast = value_end,
//                                               tuser = {key_found, byte_valid}
// apb       in   key_text @ 0x0, key_length @ 0x8 (64-bit data)
//
// One byte per cycle unless the result stalls: input register, one pass of scan
// logic, result register. Bytes that yield nothing produce no result. Async
// active-low reset clears state and keys. A stalled result holds; the input
// register still drains while the result register is free or being taken, so
// tready drops only on a full stall.
module form_field_value_extractor_top
	import ffve_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] key_found

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] key_text_q;
	logic [3:0]  key_length_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_bvalid_q;
	logic        out_end_q;
	logic        out_found_q;

	ffve_res_t   res;
	logic        adv;
	logic        load;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_KEY_LENGTH) ? {60'd0, key_length_q} : key_text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q   <= 64'd0;
			key_length_q <= 4'd0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == REG_KEY_TEXT) begin
				key_text_q <= pwdata;
			end else begin
				key_length_q <= pwdata[3:0];
			end
		end
	end

	assign adv  = valid_s1 && (!res.has || !out_valid_q || m_axis_tready);
	assign load = adv && res.has;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	ffve_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.key_text    (key_text_q),
		.key_length  (key_length_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= res.value_byte;
			out_bvalid_q <= res.byte_valid;
			out_end_q    <= res.value_end;
			out_found_q  <= res.key_found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = {out_found_q, out_bvalid_q};

endmodule
